/* design/sorted_priority_queue_unit_macros.svh */
// Assertion macros for the sorted priority queue checker.
// Needs nothing but a clock and an active-low reset at the point of use.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies.
package spq_pkg;

	localparam int VALUE_W     = 32;
	localparam int PRIO_IN_W   = 8;
	localparam int COUNT_OUT_W = 5;
	localparam int STATUS_W    = 2;
	localparam int S_TDATA_W   = 40;
	localparam int M_TDATA_W   = 48;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_PUSH,
		OP_POP
	} spq_op_t;

	typedef struct packed {
		spq_op_t op;
		logic    occupied;
	} spq_ctl_t;

endpackage

/* design/spq_cell.sv */
// One slot of the sorted queue chain: holds a value and its priority.
// Depends on spq_pkg for the control struct.
module spq_cell #(
	parameter int PW = 8
) (
	input  logic                     clk,
	input  spq_pkg::spq_ctl_t        ctl,
	input  logic [spq_pkg::VALUE_W-1:0] new_value,
	input  logic [PW-1:0]            new_prio,
	input  logic [spq_pkg::VALUE_W-1:0] left_value,
	input  logic [PW-1:0]            left_prio,
	input  logic                     left_keep,
	input  logic [spq_pkg::VALUE_W-1:0] right_value,
	input  logic [PW-1:0]            right_prio,
	output logic                     keep,
	output logic [spq_pkg::VALUE_W-1:0] value_q,
	output logic [PW-1:0]            prio_q,
	output logic [spq_pkg::VALUE_W-1:0] nxt_value,
	output logic [PW-1:0]            nxt_prio
);
	import spq_pkg::*;

	// stay put on push when this entry is served before or ties with the new one
	assign keep = ctl.occupied && (prio_q <= new_prio);

	always_comb begin
		nxt_value = value_q;
		nxt_prio  = prio_q;
		case (ctl.op)
			OP_PUSH: begin
				if (keep) begin
					nxt_value = value_q;
					nxt_prio  = prio_q;
				end else if (left_keep) begin
					nxt_value = new_value;
					nxt_prio  = new_prio;
				end else begin
					nxt_value = left_value;
					nxt_prio  = left_prio;
				end
			end
			OP_POP: begin
				nxt_value = right_value;
				nxt_prio  = right_prio;
			end
			default: begin
				nxt_value = value_q;
				nxt_prio  = prio_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= nxt_value;
		prio_q  <= nxt_prio;
	end

endmodule

/* design/sorted_priority_queue_unit.sv */
// Output: each accepted input word gives a registered result word in the next cycle.
// Throughput: one push or pop per cycle unless stalled; every cell compares its priority
// with the new one in parallel and picks its own, its neighbor's or the new entry.
// Reset: arst_n clears the entry count and the output valid; slot contents
// stay undefined and are never shown while unoccupied. No clearing pass.
module sorted_priority_queue_unit #(
	parameter int DEPTH     = 16,
	parameter int PRIO_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0] s_tdata, // item_value[31:0], item_priority[39:32]
	input  logic [0:0] s_tuser,                     // mode[0]
	output logic m_tvalid,
	input  logic m_tready,
	// head_value[31:0], head_priority[39:32], queue_empty[40], queue_full[41],
	// entry_count[46:42], zero[47]
	output logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
	output logic [spq_pkg::STATUS_W-1:0] m_tuser   // status[1:0]
);
	import spq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic                accept;
	logic                in_mode;
	logic [VALUE_W-1:0]  in_value;
	logic [PRIO_IN_W-1:0] in_prio_raw;
	logic [PRIO_BITS-1:0] in_prio;
	logic                push_ok;
	logic                pop_ok;
	spq_op_t             op;
	logic [STATUS_W-1:0] status_nxt;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_nxt;

	logic [VALUE_W-1:0]   cell_value [DEPTH];
	logic [PRIO_BITS-1:0] cell_prio  [DEPTH];
	logic [VALUE_W-1:0]   cell_nvalue [DEPTH];
	logic [PRIO_BITS-1:0] cell_nprio  [DEPTH];
	logic                 cell_keep  [DEPTH];

	logic                 m_valid_q;
	logic [VALUE_W-1:0]   head_value_q;
	logic [PRIO_IN_W-1:0] head_prio_q;
	logic                 empty_q;
	logic                 full_q;
	logic [COUNT_OUT_W-1:0] count_out_q;
	logic [STATUS_W-1:0]  status_q;
	logic [PRIO_IN_W-1:0] head_prio_nxt;
	logic [COUNT_OUT_W-1:0] count_out_nxt;

	assign in_mode     = s_tuser[0];
	assign in_value    = s_tdata[VALUE_W-1:0];
	assign in_prio_raw = s_tdata[VALUE_W+PRIO_IN_W-1:VALUE_W];

	// fit the 8-bit priority field to the stored width and back
	generate
		if (PRIO_BITS >= PRIO_IN_W) begin : g_prio_wide
			assign in_prio       = PRIO_BITS'(in_prio_raw);
			assign head_prio_nxt = (count_nxt != '0) ? cell_nprio[0][PRIO_IN_W-1:0] : '0;
		end else begin : g_prio_narrow
			assign in_prio       = in_prio_raw[PRIO_BITS-1:0];
			assign head_prio_nxt = (count_nxt != '0) ? PRIO_IN_W'(cell_nprio[0]) : '0;
		end
		if (CW >= COUNT_OUT_W) begin : g_cnt_wide
			assign count_out_nxt = count_nxt[COUNT_OUT_W-1:0];
		end else begin : g_cnt_narrow
			assign count_out_nxt = COUNT_OUT_W'(count_nxt);
		end
	endgenerate

	// take a new word whenever the output register is free or being drained
	assign s_tready = !m_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign push_ok = (in_mode == MODE_PUSH) && (count_q != CW'(DEPTH));
	assign pop_ok  = (in_mode == MODE_POP) && (count_q != '0);

	always_comb begin
		op         = OP_HOLD;
		status_nxt = ST_DONE;
		count_nxt  = count_q;
		if (accept) begin
			if (push_ok) begin
				op        = OP_PUSH;
				count_nxt = count_q + CW'(1);
			end else if (pop_ok) begin
				op        = OP_POP;
				count_nxt = count_q - CW'(1);
			end else if (in_mode == MODE_POP) begin
				status_nxt = ST_POP_EMPTY;
			end else begin
				status_nxt = ST_PUSH_FULL;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			spq_ctl_t             ctl;
			logic [VALUE_W-1:0]   lv;
			logic [PRIO_BITS-1:0] lp;
			logic                 lk;
			logic [VALUE_W-1:0]   rv;
			logic [PRIO_BITS-1:0] rp;

			assign ctl.op       = op;
			assign ctl.occupied = (CW'(gi) < count_q);

			if (gi == 0) begin : g_first
				assign lv = in_value;
				assign lp = in_prio;
				assign lk = 1'b1;
			end else begin : g_mid
				assign lv = cell_value[gi-1];
				assign lp = cell_prio[gi-1];
				assign lk = cell_keep[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign rv = cell_value[gi];
				assign rp = cell_prio[gi];
			end else begin : g_inner
				assign rv = cell_value[gi+1];
				assign rp = cell_prio[gi+1];
			end

			spq_cell #(
				.PW(PRIO_BITS)
			) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.new_value  (in_value),
				.new_prio   (in_prio),
				.left_value (lv),
				.left_prio  (lp),
				.left_keep  (lk),
				.right_value(rv),
				.right_prio (rp),
				.keep       (cell_keep[gi]),
				.value_q    (cell_value[gi]),
				.prio_q     (cell_prio[gi]),
				.nxt_value  (cell_nvalue[gi]),
				.nxt_prio   (cell_nprio[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_value_q <= (count_nxt != '0) ? cell_nvalue[0] : '0;
			head_prio_q  <= head_prio_nxt;
			empty_q      <= (count_nxt == '0);
			full_q       <= (count_nxt == CW'(DEPTH));
			count_out_q  <= count_out_nxt;
			status_q     <= status_nxt;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, count_out_q, full_q, empty_q, head_prio_q, head_value_q};
	assign m_tuser  = status_q;

endmodule

/* design/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_unit_macros.svh.
`include "sorted_priority_queue_unit_macros.svh"

module spq_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [spq_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [spq_pkg::STATUS_W-1:0] m_tuser
);
	import spq_pkg::*;

	logic                   empty;
	logic                   full;
	logic [COUNT_OUT_W-1:0] count;

	assign empty = m_tdata[40];
	assign full  = m_tdata[41];
	assign count = m_tdata[46:42];

	`SPQ_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result word changed")
	`SPQ_ASSERT_NEXT(a_word_out, clk, arst_n, s_tvalid && s_tready, m_tvalid, "accepted word gave no result")
	`SPQ_ASSERT_SAME(a_empty_cnt, clk, arst_n, m_tvalid, empty == (count == '0), "empty flag disagrees with count")
	`SPQ_ASSERT_SAME(a_pop_empty, clk, arst_n, m_tvalid && (m_tuser == ST_POP_EMPTY), empty && (m_tdata[39:0] == '0), "ignored pop on non-empty queue")
	`SPQ_ASSERT_SAME(a_push_full, clk, arst_n, m_tvalid && (m_tuser == ST_PUSH_FULL), full && !empty, "dropped push on non-full queue")

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);
